// ===== rtl/dss_pkg.sv =====
package dss_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_TRAV = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [1:0]               cmd;
    logic                     stack_sel;
    logic signed [DATA_W-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data_out;
    logic                     last;
  } out_word_t;

endpackage

// ===== rtl/dss_ram.sv =====
module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/dual_stack_shared_store_unit.sv =====
// Two stacks share one store of DEPTH words: the low stack grows upward from
// entry 0, the high stack downward from the last entry, so overflow is
// reported only when both together hold DEPTH words. A command is taken when
// start is high and busy is low. Push and pop each give one word on
// out_valid the cycle after they are taken; a new command can be taken in
// that same cycle. A traverse of n elements reads the store once per cycle,
// gives its n words one per cycle and holds busy high while it reads all but
// the first; an empty stack gives one word. Words are shown for a single cycle
// and cannot be held off. Command code 3 gives no word and changes nothing.
module dual_stack_shared_store_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dss_pkg::in_word_t  in_word,
  output logic               out_valid,
  output dss_pkg::out_word_t out_word
);

  import dss_pkg::*;

  typedef enum logic {S_IDLE, S_TRAV} state_t;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   low_count_r, low_count_nxt;
  logic [CNT_W-1:0]   high_count_r, high_count_nxt;
  logic [IDX_W-1:0]   trav_addr_r, trav_addr_nxt;
  logic               trav_up_r, trav_up_nxt;
  logic [CNT_W-1:0]   trav_rem_r, trav_rem_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_sel_r, out_sel_nxt;

  logic               accept;
  logic [CNT_W-1:0]   sel_cnt;
  logic [CNT_W:0]     used;
  logic               full;
  logic [CNT_W-1:0]   low_top;
  logic [CNT_W-1:0]   high_top;
  logic [CNT_W-1:0]   high_push;
  logic [IDX_W-1:0]   top_addr;

  logic               ram_en;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_addr;
  logic [DATA_W-1:0]  ram_rdata;

  assign accept    = start && !busy;
  assign sel_cnt   = in_word.stack_sel ? high_count_r : low_count_r;
  assign used      = {1'b0, low_count_r} + {1'b0, high_count_r};
  assign full      = used >= {1'b0, DEPTH_C};
  assign low_top   = low_count_r - CNT_W'(1);
  assign high_top  = DEPTH_C - high_count_r;
  assign high_push = high_top - CNT_W'(1);
  assign top_addr  = in_word.stack_sel ? high_top[IDX_W-1:0] : low_top[IDX_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    low_count_nxt  = low_count_r;
    high_count_nxt = high_count_r;
    trav_addr_nxt  = trav_addr_r;
    trav_up_nxt    = trav_up_r;
    trav_rem_nxt   = trav_rem_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_last_nxt   = 1'b1;
    out_sel_nxt    = 1'b0;
    ram_en         = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = top_addr;

    if (state_r == S_TRAV) begin
      ram_en        = 1'b1;
      ram_addr      = trav_addr_r;
      out_valid_nxt = 1'b1;
      out_sel_nxt   = 1'b1;
      out_last_nxt  = (trav_rem_r == CNT_W'(1));
      trav_rem_nxt  = trav_rem_r - CNT_W'(1);
      trav_addr_nxt = trav_up_r ? trav_addr_r + IDX_W'(1) : trav_addr_r - IDX_W'(1);
      if (trav_rem_r == CNT_W'(1)) begin
        state_nxt = S_IDLE;
      end
    end else if (accept) begin
      unique case (in_word.cmd)
        CMD_PUSH: begin
          out_valid_nxt = 1'b1;
          if (full) begin
            out_status_nxt = ST_OVERFLOW;
          end else begin
            ram_en = 1'b1;
            ram_we = 1'b1;
            if (in_word.stack_sel) begin
              ram_addr       = high_push[IDX_W-1:0];
              high_count_nxt = high_count_r + CNT_W'(1);
            end else begin
              ram_addr      = low_count_r[IDX_W-1:0];
              low_count_nxt = low_count_r + CNT_W'(1);
            end
          end
        end
        CMD_POP: begin
          out_valid_nxt = 1'b1;
          if (sel_cnt == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            ram_en      = 1'b1;
            out_sel_nxt = 1'b1;
            if (in_word.stack_sel) begin
              high_count_nxt = high_count_r - CNT_W'(1);
            end else begin
              low_count_nxt = low_count_r - CNT_W'(1);
            end
          end
        end
        CMD_TRAV: begin
          out_valid_nxt = 1'b1;
          if (sel_cnt == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            ram_en        = 1'b1;
            out_sel_nxt   = 1'b1;
            out_last_nxt  = (sel_cnt == CNT_W'(1));
            trav_up_nxt   = in_word.stack_sel;
            trav_rem_nxt  = sel_cnt - CNT_W'(1);
            trav_addr_nxt = in_word.stack_sel ? top_addr + IDX_W'(1)
                                              : top_addr - IDX_W'(1);
            if (sel_cnt != CNT_W'(1)) begin
              state_nxt = S_TRAV;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      low_count_r  <= '0;
      high_count_r <= '0;
      trav_rem_r   <= '0;
      trav_up_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_OK;
      out_last_r   <= 1'b0;
      out_sel_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      low_count_r  <= low_count_nxt;
      high_count_r <= high_count_nxt;
      trav_rem_r   <= trav_rem_nxt;
      trav_up_r    <= trav_up_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
      out_sel_r    <= out_sel_nxt;
    end
    trav_addr_r <= trav_addr_nxt;
  end

  dss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_word.push_value),
    .rdata (ram_rdata)
  );

  assign busy              = (state_r == S_TRAV);
  assign out_valid         = out_valid_r;
  assign out_word.status   = out_status_r;
  assign out_word.data_out = out_sel_r ? ram_rdata : '0;
  assign out_word.last     = out_last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, low_count_r} + {1'b0, high_count_r}) <= {1'b0, DEPTH_C})
    else $error("stacks hold more than the store");

  a_trav_streams: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> out_valid)
    else $error("traverse cycle without a word");

  a_trav_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> $stable(low_count_r) && $stable(high_count_r))
    else $error("stack count moved during traverse");

  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != ST_OK |-> out_word.data_out == '0 && out_word.last)
    else $error("error word carries data or is not last");

  a_trav_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    busy && trav_rem_r == CNT_W'(1) |=> !busy && out_word.last)
    else $error("traverse did not end with last");

endmodule
